[design/gtp_pkg.sv]
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants of the go-to-point controller
// Payload structs, the vector that travels down the CORDIC chain, the
// configuration register set and the arctangent table.
// ----------------------------------------------------------------------------
package gtp_pkg;

    // datapath widths
    localparam int XW         = 36;   // CORDIC x/y, signed
    localparam int AW         = 34;   // angle accumulator, signed Q2.30
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TURN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_LIM  = 3'd4;

    // register reset values
    localparam logic [15:0] HEADING_GAIN_RST = 16'd640;
    localparam logic [15:0] SPEED_GAIN_RST   = 16'd461;
    localparam logic [30:0] MAX_SPEED_RST    = 31'd13107;
    localparam logic [14:0] MAX_TURN_RST     = 15'd12288;
    localparam logic [14:0] HEADING_LIM_RST  = 15'd3217;

    // angle and gain constants
    localparam logic signed [AW-1:0] PI_HALF_Q30  = 34'sd1686629713;
    localparam logic signed [17:0]   PI_Q13       = 18'sd25736;
    localparam logic signed [17:0]   TWO_PI_Q13   = 18'sd51472;
    localparam logic [31:0]          INV_GAIN_Q32 = 32'd2608131496;

    typedef struct packed {
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] robot_heading;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
    } t_pose_in;

    typedef struct packed {
        logic [30:0]        forward_speed;
        logic signed [15:0] turn_rate;
        logic signed [15:0] bearing_error;
        logic [31:0]        target_distance;
    } t_cmd_out;

    // vector handed from cell to cell
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [AW-1:0] ang;
        logic signed [15:0]   heading;
    } t_vec;

    typedef struct packed {
        logic [15:0] heading_gain;
        logic [15:0] speed_gain;
        logic [30:0] max_forward_speed;
        logic [14:0] max_turn_rate;
        logic [14:0] heading_limit;
    } t_cfg;

    // arctangent of 2^-idx in Q2.30
    function automatic logic [30:0] atan_q30(input int unsigned idx);
        logic [30:0] v;
        unique case (idx)
            0:  v = 31'd843314856;
            1:  v = 31'd497837829;
            2:  v = 31'd263043836;
            3:  v = 31'd133525158;
            4:  v = 31'd67021686;
            5:  v = 31'd33543515;
            6:  v = 31'd16775850;
            7:  v = 31'd8388437;
            8:  v = 31'd4194282;
            9:  v = 31'd2097149;
            10: v = 31'd1048575;
            11: v = 31'd524287;
            12: v = 31'd262143;
            13: v = 31'd131071;
            14: v = 31'd65535;
            15: v = 31'd32767;
            16: v = 31'd16383;
            17: v = 31'd8191;
            18: v = 31'd4095;
            19: v = 31'd2047;
            20: v = 31'd1023;
            21: v = 31'd511;
            22: v = 31'd255;
            23: v = 31'd127;
            24: v = 31'd63;
            25: v = 31'd31;
            26: v = 31'd15;
            27: v = 31'd8;
            28: v = 31'd4;
            29: v = 31'd2;
            30: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

[design/gtp_prerot.sv]
// ----------------------------------------------------------------------------
// gtp_prerot: target vector and quadrant pre-rotation
// Forms (target - robot) and turns it into the right half plane by
// +/-pi/2, seeding the angle accumulator of the CORDIC chain.
// ----------------------------------------------------------------------------
module gtp_prerot (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  gtp_pkg::t_pose_in i_data,
    output logic              o_valid,
    output gtp_pkg::t_vec     o_vec
);

    logic signed [32:0]            dx, dy;
    logic signed [gtp_pkg::XW-1:0] ex, ey;
    gtp_pkg::t_vec                 n_vec;
    gtp_pkg::t_vec                 r_vec;
    logic                          r_valid;

    // exact differences, then rotate left half plane by +/-pi/2
    always_comb begin
        dx = {i_data.target_x[31], i_data.target_x} - {i_data.robot_x[31], i_data.robot_x};
        dy = {i_data.target_y[31], i_data.target_y} - {i_data.robot_y[31], i_data.robot_y};
        ex = {{(gtp_pkg::XW-33){dx[32]}}, dx};
        ey = {{(gtp_pkg::XW-33){dy[32]}}, dy};
        n_vec.heading = i_data.robot_heading;
        n_vec.x       = ex;
        n_vec.y       = ey;
        n_vec.ang     = '0;
        if (ex[gtp_pkg::XW-1]) begin
            if (!ey[gtp_pkg::XW-1]) begin
                n_vec.x   = ey;
                n_vec.y   = -ex;
                n_vec.ang = gtp_pkg::PI_HALF_Q30;
            end else begin
                n_vec.x   = -ey;
                n_vec.y   = ex;
                n_vec.ang = -gtp_pkg::PI_HALF_Q30;
            end
        end
    end

    // advance valid with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

[design/gtp_cordic_cell.sv]
// ----------------------------------------------------------------------------
// gtp_cordic_cell: one CORDIC vectoring iteration
// Rotates the vector toward the x axis by atan(2^-STAGE_IDX) and updates
// the angle accumulator; one register stage per cell.
// ----------------------------------------------------------------------------
module gtp_cordic_cell #(
    parameter int STAGE_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  gtp_pkg::t_vec i_vec,
    output logic          o_valid,
    output gtp_pkg::t_vec o_vec
);

    logic signed [gtp_pkg::XW-1:0] xs, ys;
    logic signed [gtp_pkg::AW-1:0] ang_step;
    gtp_pkg::t_vec                 n_vec;
    gtp_pkg::t_vec                 r_vec;
    logic                          r_valid;

    // rotate by the sign of y; leave the vector alone when y is zero
    always_comb begin
        xs       = i_vec.x >>> STAGE_IDX;
        ys       = i_vec.y >>> STAGE_IDX;
        ang_step = $signed({3'b000, gtp_pkg::atan_q30(STAGE_IDX)});
        n_vec    = i_vec;
        if (!i_vec.y[gtp_pkg::XW-1] && (i_vec.y != '0)) begin
            n_vec.x   = i_vec.x + ys;
            n_vec.y   = i_vec.y - xs;
            n_vec.ang = i_vec.ang + ang_step;
        end else if (i_vec.y[gtp_pkg::XW-1]) begin
            n_vec.x   = i_vec.x - ys;
            n_vec.y   = i_vec.y + xs;
            n_vec.ang = i_vec.ang - ang_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

[design/gtp_post.sv]
// ----------------------------------------------------------------------------
// gtp_post: bearing, distance, error and command stages
// Rounds the bearing, scales the CORDIC length, wraps the heading error,
// applies the gains and limits, and holds the result in the output register.
// ----------------------------------------------------------------------------
module gtp_post (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  gtp_pkg::t_vec     i_vec,
    input  gtp_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output gtp_pkg::t_cmd_out o_data
);

    localparam int XW = gtp_pkg::XW;
    localparam int AW = gtp_pkg::AW;

    // stage A: bearing and length partial products
    logic signed [AW:0]    ang_rnd;
    logic signed [AW-17:0] brg_wide;
    logic signed [15:0]    n_a_brg;
    logic [XW-2:0]         ux;
    logic [XW+14:0]        n_a_phi;
    logic [47:0]           plo_full;
    logic                  r_a_valid;
    logic [XW+14:0]        r_a_phi;
    logic [31:0]           r_a_plo;
    logic signed [15:0]    r_a_brg;
    logic signed [15:0]    r_a_hd;

    always_comb begin
        ang_rnd  = {i_vec.ang[AW-1], i_vec.ang} + $signed((AW+1)'(65536));
        brg_wide = ang_rnd[AW:17];
        if (brg_wide > gtp_pkg::PI_Q13) begin
            n_a_brg = gtp_pkg::PI_Q13[15:0];
        end else if (brg_wide < -gtp_pkg::PI_Q13) begin
            n_a_brg = -gtp_pkg::PI_Q13[15:0];
        end else begin
            n_a_brg = brg_wide[15:0];
        end
        ux = (!i_vec.x[XW-1] && (i_vec.x != '0)) ? i_vec.x[XW-2:0] : '0;
        n_a_phi  = (XW+15)'(ux[XW-2:16]) * (XW+15)'(gtp_pkg::INV_GAIN_Q32);
        plo_full = 48'(ux[15:0]) * 48'(gtp_pkg::INV_GAIN_Q32);
    end

    // stage B: distance sum and wrapped heading error
    logic [XW+15:0]     dsum;
    logic [XW-1:0]      dshift;
    logic [31:0]        n_b_dist;
    logic signed [17:0] err_raw;
    logic signed [17:0] err_wrap;
    logic               r_b_valid;
    logic [31:0]        r_b_dist;
    logic signed [15:0] r_b_err;

    always_comb begin
        dsum     = (XW+16)'(r_a_phi) + (XW+16)'(r_a_plo);
        dshift   = dsum[XW+15:16];
        n_b_dist = (|dshift[XW-1:32]) ? 32'hFFFF_FFFF : dshift[31:0];
        err_raw  = {{2{r_a_brg[15]}}, r_a_brg} - {{2{r_a_hd[15]}}, r_a_hd};
        err_wrap = err_raw;
        if (err_raw < -gtp_pkg::PI_Q13) begin
            err_wrap = err_raw + gtp_pkg::TWO_PI_Q13;
        end
        if (err_wrap > gtp_pkg::PI_Q13) begin
            err_wrap = err_wrap - gtp_pkg::TWO_PI_Q13;
        end
    end

    // stage C: gain products and heading test
    logic signed [32:0] n_c_tprod;
    logic [47:0]        n_c_sprod;
    logic signed [16:0] err17;
    logic [16:0]        aerr;
    logic               r_c_valid;
    logic signed [32:0] r_c_tprod;
    logic [47:0]        r_c_sprod;
    logic signed [15:0] r_c_err;
    logic [31:0]        r_c_dist;
    logic               r_c_over;

    always_comb begin
        n_c_tprod = $signed({1'b0, i_cfg.heading_gain}) * r_b_err;
        n_c_sprod = 48'(i_cfg.speed_gain) * 48'(r_b_dist);
        err17     = {r_b_err[15], r_b_err};
        aerr      = err17[16] ? 17'(-err17) : 17'(err17);
    end

    // stage D: round, limit and assemble the item
    logic signed [33:0] trnd;
    logic signed [25:0] tsh;
    logic signed [25:0] tlim;
    logic signed [15:0] n_turn;
    logic [48:0]        srnd;
    logic [40:0]        ssh;
    logic [30:0]        n_speed;
    gtp_pkg::t_cmd_out  n_out;
    logic               r_out_valid;
    gtp_pkg::t_cmd_out  r_out;

    always_comb begin
        trnd = {r_c_tprod[32], r_c_tprod} + 34'sd128;
        tsh  = trnd[33:8];
        tlim = $signed({11'b0, i_cfg.max_turn_rate});
        if (tsh > tlim) begin
            n_turn = tlim[15:0];
        end else if (tsh < -tlim) begin
            n_turn = -tlim[15:0];
        end else begin
            n_turn = tsh[15:0];
        end
        srnd = {1'b0, r_c_sprod} + 49'd128;
        ssh  = srnd[48:8];
        if (r_c_over) begin
            n_speed = '0;
        end else if (ssh > {10'b0, i_cfg.max_forward_speed}) begin
            n_speed = i_cfg.max_forward_speed;
        end else begin
            n_speed = ssh[30:0];
        end
        n_out.forward_speed   = n_speed;
        n_out.turn_rate       = n_turn;
        n_out.bearing_error   = r_c_err;
        n_out.target_distance = r_c_dist;
    end

    // advance stage valids together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_phi   <= n_a_phi;
            r_a_plo   <= plo_full[47:16];
            r_a_brg   <= n_a_brg;
            r_a_hd    <= i_vec.heading;
            r_b_dist  <= n_b_dist;
            r_b_err   <= err_wrap[15:0];
            r_c_tprod <= n_c_tprod;
            r_c_sprod <= n_c_sprod;
            r_c_err   <= r_b_err;
            r_c_dist  <= r_b_dist;
            r_c_over  <= aerr > {2'b0, i_cfg.heading_limit};
            r_out     <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[design/go_to_point_p_controller.sv]
// ----------------------------------------------------------------------------
// go_to_point_p_controller: proportional go-to-point steering controller
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_in_data  (pose, target)
//   out      output     o_out_valid / i_out_ready o_out_data (speed, turn,
//                                                  error, distance)
//   cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One item per cycle while the output is not stalled; the pipeline is the chain
// of CORDIC cells plus the pre-rotation and four post stages.
// All stages advance together whenever the output register is empty or
// its item is taken; otherwise every stage holds.
// Reset clears all valid bits and loads the default gains and limits.
// ----------------------------------------------------------------------------
module go_to_point_p_controller #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  gtp_pkg::t_pose_in                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output gtp_pkg::t_cmd_out                   o_out_data,
    input  logic                                i_cfg_we,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gtp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic          adv;
    logic          chain_valid [0:CORDIC_STAGES];
    gtp_pkg::t_vec chain_vec   [0:CORDIC_STAGES];
    gtp_pkg::t_cfg r_cfg;

    // move the whole pipeline when the output slot frees up
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heading_gain      <= gtp_pkg::HEADING_GAIN_RST;
            r_cfg.speed_gain        <= gtp_pkg::SPEED_GAIN_RST;
            r_cfg.max_forward_speed <= gtp_pkg::MAX_SPEED_RST;
            r_cfg.max_turn_rate     <= gtp_pkg::MAX_TURN_RST;
            r_cfg.heading_limit     <= gtp_pkg::HEADING_LIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gtp_pkg::CFG_HEADING_GAIN: r_cfg.heading_gain      <= i_cfg_data[15:0];
                gtp_pkg::CFG_SPEED_GAIN:   r_cfg.speed_gain        <= i_cfg_data[15:0];
                gtp_pkg::CFG_MAX_SPEED:    r_cfg.max_forward_speed <= i_cfg_data[30:0];
                gtp_pkg::CFG_MAX_TURN:     r_cfg.max_turn_rate     <= i_cfg_data[14:0];
                gtp_pkg::CFG_HEADING_LIM:  r_cfg.heading_limit     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // difference vector and quadrant fold
    gtp_prerot u_prerot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (chain_valid[0]),
        .o_vec   (chain_vec[0])
    );

    // chain of CORDIC vectoring cells
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        gtp_cordic_cell #(
            .STAGE_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (chain_valid[g]),
            .i_vec   (chain_vec[g]),
            .o_valid (chain_valid[g+1]),
            .o_vec   (chain_vec[g+1])
        );
    end

    // bearing, distance and command stages
    gtp_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (chain_valid[CORDIC_STAGES]),
        .i_vec   (chain_vec[CORDIC_STAGES]),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

[design/gtp_checker.sv]
// ----------------------------------------------------------------------------
// gtp_checker: port-level checks of the go-to-point controller
// Watches the top-level ports for output holding, result ranges, input
// readiness and reset behavior.
// ----------------------------------------------------------------------------
module gtp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input gtp_pkg::t_cmd_out              o_out_data
);

    // a stalled item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");

    // wrapped error stays within +/-pi
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out_data.bearing_error) <= 16'sd25736) &&
                        ($signed(o_out_data.bearing_error) >= -16'sd25736))
        else $error("bearing error out of range");

    // no speed without distance
    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.target_distance == 32'd0) |->
            (o_out_data.forward_speed == 31'd0))
        else $error("speed commanded at zero distance");

    // empty output slot always takes an item
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // reset drops any pending item
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind go_to_point_p_controller gtp_checker u_gtp_checker (.*);

[tb/steer_cmd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// steer_cmd_checker: predictor and scoreboard for the go-to-point controller
// Watches the pose, command and register ports, works out the command that
// each accepted pose must produce and compares every command that leaves the
// block, in order, field by field.
// ----------------------------------------------------------------------------
module steer_cmd_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  gtp_pkg::t_pose_in                  i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  gtp_pkg::t_cmd_out                  i_out_data,
    input  logic                               i_cfg_we,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [gtp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_speed_cut,
    output int                                 o_turn_held
);

    localparam longint          HALF_PI_Q30 = 64'sd1686629713;
    localparam longint          PI_ANGLE    = 25736;
    localparam longint          FULL_TURN   = 51472;
    localparam longint unsigned DIST_SCALE  = 64'd2608131496;
    localparam longint unsigned DIST_CEIL   = 64'hFFFF_FFFF;

    // arctangent of 2^-i, Q2.30
    longint atan_tab [32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2, 1, 0
    };

    // shadow copy of the register set
    logic [15:0] hdg_gain;
    logic [15:0] spd_gain;
    logic [30:0] spd_cap;
    logic [14:0] turn_cap;
    logic [14:0] hdg_limit;

    gtp_pkg::t_cmd_out pending_cmds [$];

    // command for one pose under the current registers
    function automatic gtp_pkg::t_cmd_out steer_cmd_for(input gtp_pkg::t_pose_in p,
            output bit speed_cut, output bit turn_held);
        longint x, y, nx, xs, ys, ang, bearing, err, turn;
        longint unsigned ux, dist_q16, speed, aerr;
        gtp_pkg::t_cmd_out c;
        x   = longint'($signed(p.target_x)) - longint'($signed(p.robot_x));
        y   = longint'($signed(p.target_y)) - longint'($signed(p.robot_y));
        ang = 0;
        // fold the left half plane over by a quarter turn
        if (x < 0) begin
            if (y >= 0) begin
                nx  = y;
                y   = -x;
                ang = HALF_PI_Q30;
            end else begin
                nx  = -y;
                y   = x;
                ang = -HALF_PI_Q30;
            end
            x = nx;
        end
        // vectoring: drive y to zero, collect the angle
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x   = x + ys;
                y   = y - xs;
                ang = ang + atan_tab[i];
            end else if (y < 0) begin
                x   = x - ys;
                y   = y + xs;
                ang = ang - atan_tab[i];
            end
        end
        bearing = (ang + 64'sd65536) >>> 17;
        if (bearing > PI_ANGLE)
            bearing = PI_ANGLE;
        if (bearing < -PI_ANGLE)
            bearing = -PI_ANGLE;

        // remove the CORDIC gain from the length
        ux       = (x > 0) ? longint'(x) : 64'd0;
        dist_q16 = ((ux >> 16) * DIST_SCALE + (((ux & 64'hFFFF) * DIST_SCALE) >> 16)) >> 16;
        if (dist_q16 > DIST_CEIL)
            dist_q16 = DIST_CEIL;

        // heading error, wrapped at most once
        err = bearing - longint'($signed(p.robot_heading));
        if (err < -PI_ANGLE)
            err = err + FULL_TURN;
        if (err > PI_ANGLE)
            err = err - FULL_TURN;

        turn      = (longint'(hdg_gain) * err + 128) >>> 8;
        turn_held = (turn > longint'(turn_cap)) || (turn < -longint'(turn_cap));
        if (turn > longint'(turn_cap))
            turn = longint'(turn_cap);
        if (turn < -longint'(turn_cap))
            turn = -longint'(turn_cap);

        speed = (64'(spd_gain) * dist_q16 + 64'd128) >> 8;
        if (speed > 64'(spd_cap))
            speed = 64'(spd_cap);
        aerr      = (err < 0) ? -err : err;
        speed_cut = aerr > 64'(hdg_limit);
        if (speed_cut)
            speed = 0;

        c.forward_speed   = speed[30:0];
        c.turn_rate       = turn[15:0];
        c.bearing_error   = err[15:0];
        c.target_distance = dist_q16[31:0];
        return c;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
            input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    // match commands, queue predictions, track register writes
    always @(posedge i_clk) begin : watch
        gtp_pkg::t_cmd_out want;
        bit                cut;
        bit                held;
        if (!i_rst_n) begin
            hdg_gain  <= 16'd640;
            spd_gain  <= 16'd461;
            spd_cap   <= 31'd13107;
            turn_cap  <= 15'd12288;
            hdg_limit <= 15'd3217;
            pending_cmds.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_speed_cut  = 0;
            o_turn_held  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_cmds.size() == 0) begin
                    $error("command item left the block with no pose pending");
                    o_fail_count++;
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("forward_speed", want.forward_speed,
                                i_out_data.forward_speed);
                    check_field("turn_rate", $signed(want.turn_rate),
                                $signed(i_out_data.turn_rate));
                    check_field("bearing_error", $signed(want.bearing_error),
                                $signed(i_out_data.bearing_error));
                    check_field("target_distance", want.target_distance,
                                i_out_data.target_distance);
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_cmds.push_back(steer_cmd_for(i_in_data, cut, held));
                if (cut)
                    o_speed_cut++;
                if (held)
                    o_turn_held++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gtp_pkg::CFG_HEADING_GAIN: hdg_gain  <= i_cfg_data[15:0];
                    gtp_pkg::CFG_SPEED_GAIN:   spd_gain  <= i_cfg_data[15:0];
                    gtp_pkg::CFG_MAX_SPEED:    spd_cap   <= i_cfg_data[30:0];
                    gtp_pkg::CFG_MAX_TURN:     turn_cap  <= i_cfg_data[14:0];
                    gtp_pkg::CFG_HEADING_LIM:  hdg_limit <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
        o_pending = pending_cmds.size();
    end

endmodule

[tb/go_to_point_p_controller_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_to_point_p_controller_tb: stimulus and verdict for the steering block
// Sends a short directed set of poses, then random poses in bursts under a
// series of register settings, while the command side stalls on its own
// pattern. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module go_to_point_p_controller_tb;

    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = CORDIC_STAGES + 5;
    localparam int IDX_W         = gtp_pkg::CFG_IDX_W;
    localparam int DATA_W        = gtp_pkg::CFG_DATA_W;
    localparam int CFG_SLOTS     = 1 << IDX_W;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    gtp_pkg::t_pose_in     i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    gtp_pkg::t_cmd_out     o_out_data;
    logic                  i_cfg_we;
    logic [IDX_W-1:0]      i_cfg_idx;
    logic [DATA_W-1:0]     i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int speed_cut;
    int turn_held;
    int settings_run;
    int stray_writes;

    go_to_point_p_controller #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    steer_cmd_checker #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_speed_cut  (speed_cut),
        .o_turn_held  (turn_held)
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2000000;
        $display("run timed out with %0d commands outstanding", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // command side: pick a random stall pattern and span, then switch to another
    initial begin : out_stall
        int mode;
        int span;
        int tick;
        i_out_ready = 1'b0;
        mode = 0;
        span = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                mode = $urandom_range(0, 4);
                span = $urandom_range(20, 200);
            end
            span--;
            tick++;
            case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 1) != 0);
                3: i_out_ready <= ((tick % 5) != 0);
                default: i_out_ready <= ((tick % 24) < 8);
            endcase
        end
    end

    function automatic gtp_pkg::t_pose_in make_pose(input int rx, input int ry, input int hd,
            input int tx, input int ty);
        gtp_pkg::t_pose_in p;
        p.robot_x       = rx;
        p.robot_y       = ry;
        p.robot_heading = 16'(hd);
        p.target_x      = tx;
        p.target_y      = ty;
        return p;
    endfunction

    // mostly a nearby target with a heading roughly toward it; some noise
    function automatic gtp_pkg::t_pose_in random_pose();
        gtp_pkg::t_pose_in p;
        longint            dx, dy, span;
        int                k, aim, jit;
        p.robot_x       = $urandom();
        p.robot_y       = $urandom();
        p.robot_heading = 16'($urandom());
        case ($urandom_range(0, 9))
            0, 1: begin
                p.target_x = $urandom();
                p.target_y = $urandom();
            end
            2: begin
                p.target_x = p.robot_x;
                p.target_y = p.robot_y;
            end
            default: begin
                k    = $urandom_range(0, 30);
                span = longint'(1) << k;
                dx   = longint'($urandom_range(0, 32'(2 * span - 1))) - span;
                dy   = longint'($urandom_range(0, 32'(2 * span - 1))) - span;
                p.target_x = 32'(longint'(p.robot_x) + dx);
                p.target_y = 32'(longint'(p.robot_y) + dy);
                dx  = longint'(p.target_x) - longint'(p.robot_x);
                dy  = longint'(p.target_y) - longint'(p.robot_y);
                aim = $rtoi($atan2(real'(dy), real'(dx)) * 8192.0);
                case ($urandom_range(0, 3))
                    0: jit = 0;
                    1: jit = 400;
                    2: jit = 3000;
                    default: jit = 9000;
                endcase
                aim = aim + int'($urandom_range(0, 2 * jit)) - jit;
                case ($urandom_range(0, 19))
                    0: p.robot_heading = 16'sd25736;
                    1: p.robot_heading = -16'sd25736;
                    2: p.robot_heading = 16'sh7FFF;
                    3: p.robot_heading = 16'sh8000;
                    default: p.robot_heading = 16'(aim);
                endcase
            end
        endcase
        return p;
    endfunction

    // offer one pose and hold it until taken; valid stays high afterwards
    task automatic send_pose(input gtp_pkg::t_pose_in p);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // random poses in bursts with random gaps, some bursts back to back
    task automatic send_batch(input int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            end
            send_pose(random_pose());
            burst--;
        end
        hold_off(1);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx,
            input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic load_settings(input logic [DATA_W-1:0] hg,
            input logic [DATA_W-1:0] sg, input logic [DATA_W-1:0] ms,
            input logic [DATA_W-1:0] mt, input logic [DATA_W-1:0] hl);
        cfg_write(gtp_pkg::CFG_HEADING_GAIN, hg);
        cfg_write(gtp_pkg::CFG_SPEED_GAIN, sg);
        cfg_write(gtp_pkg::CFG_MAX_SPEED, ms);
        cfg_write(gtp_pkg::CFG_MAX_TURN, mt);
        cfg_write(gtp_pkg::CFG_HEADING_LIM, hl);
        settings_run++;
    endtask

    initial begin : stim
        logic [DATA_W-1:0] ones;
        ones         = '1;
        settings_run = 1;
        stray_writes = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed poses under the reset settings
        send_pose(make_pose(0, 0, 0, 0, 0));
        send_pose(make_pose(32'h1234_5678, -32'sh5555, 1000, 32'h1234_5678, -32'sh5555));
        send_pose(make_pose(32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pose(make_pose(32'h7FFF_FFFF, 0, 25736, 32'h8000_0000, 0));
        send_pose(make_pose(32'h7FFF_FFFF, 0, -25736, 32'h8000_0000, 0));
        send_pose(make_pose(0, 0, 0, 0, 32'h8000_0000));
        send_pose(make_pose(0, 0, 0, -65536, -1));
        send_pose(make_pose(0, 0, 0, 65536, 0));
        send_pose(make_pose(0, 0, 0, 4096, 0));
        // heading error right at the limit, then just past it on each side
        send_pose(make_pose(0, 0, 3217, 4096, 0));
        send_pose(make_pose(0, 0, 3218, 4096, 0));
        send_pose(make_pose(0, 0, -3218, 4096, 0));
        // headings beyond pi wrap the error once
        send_pose(make_pose(0, 0, 32767, 65536, 0));
        send_pose(make_pose(0, 0, -32768, 65536, 0));
        send_pose(make_pose(0, 0, 25736, 0, 65536));
        send_pose(make_pose(0, 0, -12868, 0, 65536));
        send_pose(make_pose(0, 0, 0, -65536, 0));
        send_pose(make_pose(0, 0, 0, -1, 1));
        send_pose(make_pose(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_pose(make_pose(0, 0, 0, 1, 0));
        hold_off(1);
        drain();

        send_batch(200);
        drain();

        // everything zero: no speed, no turn
        load_settings('0, '0, '0, '0, '0);
        send_batch(150);
        drain();

        // everything at full scale; the spare data bits must be dropped
        load_settings(ones, ones, ones, ones, ones);
        send_batch(200);
        drain();

        // writes to unused indexes must leave the registers alone
        for (int idx = int'(gtp_pkg::CFG_HEADING_LIM) + 1; idx < CFG_SLOTS; idx++) begin
            cfg_write(IDX_W'(idx), DATA_W'($urandom()));
            stray_writes++;
        end
        send_batch(100);
        drain();

        load_settings(DATA_W'(gtp_pkg::HEADING_GAIN_RST), DATA_W'(gtp_pkg::SPEED_GAIN_RST),
                      DATA_W'(gtp_pkg::MAX_SPEED_RST), DATA_W'(gtp_pkg::MAX_TURN_RST),
                      DATA_W'(gtp_pkg::HEADING_LIM_RST));
        send_batch(150);
        drain();

        // random settings: raw words first, then plausible tunings
        for (int s = 0; s < 4; s++) begin
            if (s < 2)
                load_settings(DATA_W'($urandom()), DATA_W'($urandom()),
                              DATA_W'($urandom()), DATA_W'($urandom()),
                              DATA_W'($urandom()));
            else
                load_settings(DATA_W'($urandom_range(1, 1024)),
                              DATA_W'($urandom_range(1, 1024)),
                              DATA_W'($urandom_range(0, 1 << 20)),
                              DATA_W'($urandom_range(0, 32767)),
                              DATA_W'($urandom_range(0, 25736)));
            send_batch(140);
            drain();
        end

        $display("checked %0d steering commands under %0d register settings, %0d stray writes",
                 checked, settings_run, stray_writes);
        $display("speed cut by heading error on %0d, turn rate saturated on %0d",
                 speed_cut, turn_held);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
